// File: rtl/nsvl_pkg.sv
// ----------------------------------------------------------------------------
// nsvl_pkg
// Shared sizes, register codes and controller/datapath link types for the
// nearest sorted value lookup.
// ----------------------------------------------------------------------------
package nsvl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Input command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index (word address bit of paddr)
  localparam logic REG_EVENT_COUNT = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic store;     // write value into slot
    logic load;      // capture query and bounds, form first midpoint
    logic issue;     // read entry at midpoint
    logic step;      // compare midpoint entry, narrow the bounds
    logic fetch_up;  // hold lower neighbor, read upper neighbor
    logic finish;    // pick the nearer neighbor, load result
  } nsvl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic more;      // bounds still span more than one entry
  } nsvl_stat_t;

endpackage

// File: rtl/nsvl_ram.sv
// ----------------------------------------------------------------------------
// nsvl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nsvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/nsvl_datapath.sv
// ----------------------------------------------------------------------------
// nsvl_datapath
// Event table, bisection bounds, neighbor compare and result registers.
// ----------------------------------------------------------------------------
module nsvl_datapath (
  input  logic                                 clk,
  input  nsvl_pkg::nsvl_cmd_t                  cmd,
  output nsvl_pkg::nsvl_stat_t                 stat,
  input  logic [nsvl_pkg::SLOT_W-1:0]          slot,
  input  logic signed [nsvl_pkg::VALUE_BITS-1:0] value,
  input  logic [nsvl_pkg::COUNT_W-1:0]         event_count,
  output logic signed [nsvl_pkg::VALUE_BITS-1:0] nearest_value,
  output logic [nsvl_pkg::SLOT_W-1:0]          nearest_slot
);
  import nsvl_pkg::*;

  logic signed [VALUE_BITS-1:0] q;
  logic [CNT_W-1:0]             n;
  logic [ADDR_W-1:0]            lo;
  logic [CNT_W-1:0]             up;
  logic [ADDR_W-1:0]            mid;
  logic signed [VALUE_BITS-1:0] lowv;

  logic [CNT_W-1:0]             n_clamp;
  logic signed [VALUE_BITS-1:0] rdata;
  logic [ADDR_W-1:0]            raddr;
  logic                         ge;
  logic [ADDR_W-1:0]            lo_next;
  logic [CNT_W-1:0]             up_next;
  logic [CNT_W:0]               sum_next;
  logic [ADDR_W-1:0]            mid_next;
  logic [CNT_W-1:0]             span_next;
  logic [CNT_W-1:0]             lo_inc;
  logic [ADDR_W-1:0]            nxt;
  logic signed [VALUE_BITS:0]   dist_lo;
  logic signed [VALUE_BITS:0]   dist_up;
  logic                         we;

  // Clamp the count to 1..TABLE_DEPTH
  always_comb begin
    if (event_count == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(event_count) > 32'(TABLE_DEPTH)) begin
      n_clamp = CNT_W'(TABLE_DEPTH);
    end else begin
      n_clamp = CNT_W'(event_count);
    end
  end

  // Narrow the bounds from the midpoint entry
  always_comb begin
    ge        = (q >= rdata);
    lo_next   = ge ? mid : lo;
    up_next   = ge ? up : CNT_W'(mid);
    sum_next  = (CNT_W+1)'(lo_next) + (CNT_W+1)'(up_next);
    mid_next  = sum_next[ADDR_W:1];
    span_next = up_next - CNT_W'(lo_next);
    stat.more = (span_next > CNT_W'(1));
  end

  // Upper neighbor slot, clamped to the last valid entry
  always_comb begin
    lo_inc = CNT_W'(lo) + CNT_W'(1);
    if (lo_inc > n - CNT_W'(1)) begin
      nxt = ADDR_W'(n - CNT_W'(1));
    end else begin
      nxt = ADDR_W'(lo_inc);
    end
  end

  // Select the read address for this cycle
  always_comb begin
    priority if (cmd.step) begin
      raddr = stat.more ? mid_next : lo_next;
    end else if (cmd.fetch_up) begin
      raddr = nxt;
    end else begin
      raddr = mid;
    end
  end

  assign we = cmd.store && (32'(slot) < 32'(TABLE_DEPTH));

  nsvl_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(ADDR_W'(slot)),
    .wdata(value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Distances one bit wider than the values
  assign dist_lo = (VALUE_BITS+1)'(q) - (VALUE_BITS+1)'(lowv);
  assign dist_up = (VALUE_BITS+1)'(rdata) - (VALUE_BITS+1)'(q);

  // Bounds and query registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q   <= value;
      n   <= n_clamp;
      lo  <= '0;
      up  <= n_clamp;
      mid <= ADDR_W'(n_clamp >> 1);
    end else if (cmd.step) begin
      lo  <= lo_next;
      up  <= up_next;
      mid <= mid_next;
    end
  end

  // Hold the lower neighbor value
  always_ff @(posedge clk) begin
    if (cmd.fetch_up) begin
      lowv <= rdata;
    end
  end

  // Pick the upper neighbor on a tie or when nearer
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (dist_lo < dist_up) begin
        nearest_value <= lowv;
        nearest_slot  <= SLOT_W'(lo);
      end else begin
        nearest_value <= rdata;
        nearest_slot  <= SLOT_W'(nxt);
      end
    end
  end

endmodule

// File: rtl/nsvl_ctrl.sv
// ----------------------------------------------------------------------------
// nsvl_ctrl
// Sequencer for one item: store, or bisect then read both neighbors.
// ----------------------------------------------------------------------------
module nsvl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 command,
  output logic                 busy,
  output logic                 done,
  output nsvl_pkg::nsvl_cmd_t  cmd,
  input  nsvl_pkg::nsvl_stat_t stat
);
  import nsvl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_BISECT,
    S_READ_LO,
    S_READ_UP
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Decode commands from the state
  always_comb begin
    cmd          = '0;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        cmd.store = accept && (command == CMD_STORE);
        cmd.load  = accept && (command == CMD_QUERY);
        if (cmd.load) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.issue  = 1'b1;
        state_next = S_BISECT;
      end
      S_BISECT: begin
        cmd.step = 1'b1;
        if (!stat.more) begin
          state_next = S_READ_LO;
        end
      end
      S_READ_LO: begin
        cmd.fetch_up = 1'b1;
        state_next   = S_READ_UP;
      end
      S_READ_UP: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

`ifndef SYNTHESIS
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_busy_from_query : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && command == CMD_QUERY))
    else $error("busy rose without a query beat");

  a_bisect_entry : assert property (@(posedge clk) disable iff (rst)
    (state == S_BISECT) |->
      $past(state == S_READ || (state == S_BISECT && stat.more)))
    else $error("bisection step without open bounds");
`endif

endmodule

// File: rtl/nearest_sorted_value_lookup.sv
// ----------------------------------------------------------------------------
// nearest_sorted_value_lookup
// Finds the table entry nearest to a query value by bisection.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken when start is high and busy is low. command 0 stores
//   value into the table at slot; busy stays low and no result follows.
//   command 1 queries value: busy rises and the block bisects the first
//   n entries, n being event_count clamped to 1..1024, one table read per
//   cycle. The result (nearest_value, nearest_slot) appears for one cycle
//   with done high. The bisection takes at least one and at most
//   max(1, ceil(log2(n))) steps. A new beat is taken in the cycle done is
//   high. The receiver cannot stall: done is a one-cycle pulse.
//   event_count sits on the APB port at byte address 0; the user must
//   write it only while the block is idle, as the block itself does not
//   enforce this. Reset clears the sequencer and sets event_count to 1;
//   table contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_sorted_value_lookup (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   command,
  input  logic [nsvl_pkg::SLOT_W-1:0]            slot,
  input  logic signed [nsvl_pkg::VALUE_BITS-1:0] value,
  output logic                                   done,
  output logic signed [nsvl_pkg::VALUE_BITS-1:0] nearest_value,
  output logic [nsvl_pkg::SLOT_W-1:0]            nearest_slot,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [nsvl_pkg::PADDR_W-1:0]           paddr,
  input  logic [nsvl_pkg::PDATA_W-1:0]           pwdata,
  output logic [nsvl_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);
  import nsvl_pkg::*;

  logic [COUNT_W-1:0] event_count;
  nsvl_cmd_t          cmd;
  nsvl_stat_t         stat;
  logic               reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_EVENT_COUNT);

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= COUNT_W'(1);
    end else if (psel && penable && pwrite && reg_hit) begin
      event_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Register read
  assign prdata = reg_hit ? PDATA_W'(event_count) : '0;

  nsvl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .stat   (stat)
  );

  nsvl_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .slot         (slot),
    .value        (value),
    .event_count  (event_count),
    .nearest_value(nearest_value),
    .nearest_slot (nearest_slot)
  );

endmodule

// File: verif/tb_nearest_sorted_value_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_sorted_value_lookup
// Self-checking bench for the nearest sorted value lookup. A driver feeds
// store and query beats from a queue with random gaps, a monitor compares
// every result against a shadow copy of the event table bisected in the
// bench, and the event count register is moved through its extremes over
// APB between phases, with a read-back after each write.
// ----------------------------------------------------------------------------
module tb_nearest_sorted_value_lookup;
  import nsvl_pkg::*;

  localparam longint VAL_MAX      = 64'sd2147483647;
  localparam longint VAL_MIN      = -64'sd2147483648;
  localparam int     DRAIN_CYCLES = 24;

  typedef struct {
    logic                  command;
    logic [SLOT_W-1:0]     slot;
    logic [VALUE_BITS-1:0] value;
  } beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_W-1:0]     slot;
  } nearest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          start   = 1'b0;
  logic                          command = CMD_STORE;
  logic [SLOT_W-1:0]             slot    = '0;
  logic signed [VALUE_BITS-1:0]  value   = '0;
  logic                          busy;
  logic                          done;
  logic signed [VALUE_BITS-1:0]  nearest_value;
  logic [SLOT_W-1:0]             nearest_slot;

  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [PADDR_W-1:0]            paddr   = '0;
  logic [PDATA_W-1:0]            pwdata  = '0;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;

  // Shadow state of the block and the intended table used to aim queries
  logic signed [VALUE_BITS-1:0]  event_mem [TABLE_DEPTH];
  logic signed [VALUE_BITS-1:0]  plan_vals [TABLE_DEPTH];
  logic [COUNT_W-1:0]            count_reg = COUNT_W'(1);

  beat_t    pending_beats [$];
  nearest_t nearest_q [$];

  bit steady_beats = 1'b0;
  int gap_left     = 0;
  int error_count  = 0;
  int stores_taken = 0;
  int queries_taken = 0;
  int results_seen = 0;
  int settings_used = 0;

  nearest_sorted_value_lookup u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .slot          (slot),
    .value         (value),
    .done          (done),
    .nearest_value (nearest_value),
    .nearest_slot  (nearest_slot),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endfunction

  // Bisect the shadow table, then pick the nearer neighbor (upper on a tie)
  function automatic nearest_t find_nearest(logic signed [VALUE_BITS-1:0] q);
    int unsigned n, lo, hi, mid, nxt;
    logic signed [VALUE_BITS-1:0] low_v, up_v;
    logic signed [VALUE_BITS:0]   to_low, to_up;
    nearest_t r;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    lo = 0;
    hi = n;
    do begin
      mid = (lo + hi) >> 1;
      if (q >= event_mem[mid]) lo = mid;
      else hi = mid;
    end while (hi - lo > 1);
    nxt = (lo + 1 > n - 1) ? n - 1 : lo + 1;
    low_v = event_mem[lo];
    up_v  = event_mem[nxt];
    // widen by one bit so extreme distances stay exact
    to_low = $signed({q[VALUE_BITS-1], q}) - $signed({low_v[VALUE_BITS-1], low_v});
    to_up  = $signed({up_v[VALUE_BITS-1], up_v}) - $signed({q[VALUE_BITS-1], q});
    if (to_low < to_up) begin
      r.value = low_v;
      r.slot  = SLOT_W'(lo);
    end else begin
      r.value = up_v;
      r.slot  = SLOT_W'(nxt);
    end
    return r;
  endfunction

  function automatic void apply_beat(logic cmd, logic [SLOT_W-1:0] s,
                                     logic signed [VALUE_BITS-1:0] v);
    if (cmd == CMD_STORE) begin
      event_mem[s] = v;
      stores_taken++;
    end else begin
      nearest_q.push_back(find_nearest(v));
      queries_taken++;
    end
  endfunction

  function automatic int draw_gap();
    return steady_beats ? 0 : $urandom_range(0, 12);
  endfunction

  // Driver: hold a beat until taken, then wait the drawn gap before the next
  always @(posedge clk) begin
    beat_t nb;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        apply_beat(command, slot, value);
        gap_left = draw_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          nb = pending_beats.pop_front();
          start   <= 1'b1;
          command <= nb.command;
          slot    <= nb.slot;
          value   <= nb.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: match each result beat against the oldest pending answer
  always @(posedge clk) begin
    nearest_t want;
    if (!rst && done !== 1'b0) begin
      results_seen++;
      if (nearest_q.size() == 0) begin
        flag_error($sformatf("result with none pending: value %h slot %0d",
                             nearest_value, nearest_slot));
      end else begin
        want = nearest_q.pop_front();
        if (nearest_value !== want.value) begin
          flag_error($sformatf("nearest_value exp %h got %h", want.value, nearest_value));
        end
        if (nearest_slot !== want.slot) begin
          flag_error($sformatf("nearest_slot exp %0d got %0d", want.slot, nearest_slot));
        end
      end
    end
  end

  function automatic void put_store(int unsigned s, logic [VALUE_BITS-1:0] v);
    beat_t b;
    b.command = CMD_STORE;
    b.slot    = SLOT_W'(s);
    b.value   = v;
    plan_vals[b.slot] = v;
    pending_beats.push_back(b);
  endfunction

  function automatic void put_query(logic [VALUE_BITS-1:0] v);
    beat_t b;
    b.command = CMD_QUERY;
    b.slot    = SLOT_W'($urandom);
    b.value   = v;
    pending_beats.push_back(b);
  endfunction

  // Fill the first eff slots with a non-decreasing sequence of random spacing
  function automatic void build_sorted(int unsigned eff);
    longint      cur;
    int unsigned span;
    case ($urandom_range(0, 3))
      0: span = 2;
      1: span = 32'h0001_0000;
      2: span = 32'hFFFF_FFFF / (eff + 1);
      default: span = $urandom_range(1, 32'hFFFF_FFFF / (eff + 1));
    endcase
    if (span > 32'h0001_0000) cur = VAL_MIN + longint'($urandom_range(0, span));
    else cur = longint'($signed($urandom));
    for (int unsigned i = 0; i < eff; i++) begin
      plan_vals[i] = cur[VALUE_BITS-1:0];
      cur = cur + longint'($urandom_range(0, span));
      if (cur > VAL_MAX) cur = VAL_MAX;
    end
    if ($urandom_range(0, 1)) begin
      for (int i = eff - 1; i >= 0; i--) put_store(i, plan_vals[i]);
    end else begin
      for (int unsigned i = 0; i < eff; i++) put_store(i, plan_vals[i]);
    end
  endfunction

  // Aim a query at hits, ties, near misses and both ends of the table
  function automatic logic [VALUE_BITS-1:0] pick_query(int unsigned eff);
    int unsigned k;
    longint      a, b, m;
    k = $urandom_range(0, eff - 1);
    a = longint'(plan_vals[k]);
    b = longint'(plan_vals[(k + 1 < eff) ? k + 1 : k]);
    m = (a + b) >>> 1;
    case ($urandom_range(0, 9))
      0: m = a;
      1: m = a + 1;
      2: m = a - 1;
      3: m = m;
      4: m = m + 1;
      5: m = longint'($signed($urandom));
      6: m = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      7: m = longint'(plan_vals[0]) - longint'($urandom_range(1, 4096));
      8: m = longint'(plan_vals[eff - 1]) + longint'($urandom_range(1, 4096));
      default: m = a + longint'($urandom_range(0, 255));
    endcase
    return m[VALUE_BITS-1:0];
  endfunction

  // Wait until every beat is taken and answered, then let the block settle
  task automatic drain();
    while (pending_beats.size() != 0 || start || nearest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [COUNT_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(data);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(logic idx, logic [COUNT_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== want) begin
      flag_error($sformatf("event_count read exp %0d got %0d", want, prdata[COUNT_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_count(logic [COUNT_W-1:0] n);
    drain();
    reg_write(REG_EVENT_COUNT, n);
    count_reg = n;
    reg_read_check(REG_EVENT_COUNT, n);
    settings_used++;
  endtask

  // One random phase: optional sorted refill, then queries mixed with noise
  task automatic random_phase(int unsigned cfg_count, bit refill, int unsigned n_queries);
    int unsigned eff;
    set_count(COUNT_W'(cfg_count));
    eff = (cfg_count == 0) ? 1 : (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
    steady_beats = ($urandom_range(0, 3) == 0);
    if (refill) build_sorted(eff);
    repeat (n_queries) begin
      case ($urandom_range(0, 19))
        0: put_store($urandom_range(0, eff - 1), $urandom);
        1: put_store($urandom_range(0, TABLE_DEPTH - 1), $urandom);
        default: put_query(pick_query(eff));
      endcase
    end
  endtask

  initial begin
    int unsigned sizes [10];
    sizes = '{1, 2, 3, 5, 8, 16, 17, 33, 64, 300};
    sizes[8] = $urandom_range(4, 64);
    sizes[9] = $urandom_range(65, 300);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single entry from the reset count, extreme values
    put_store(0, 32'h8000_0000);
    put_query(32'h7FFF_FFFF);
    put_query(32'h8000_0000);
    put_query(32'h0000_0000);

    // Zero count acts as one; query below the first event
    set_count(COUNT_W'(0));
    put_store(0, 32'h0001_0000);
    put_query(32'h8000_0000);
    put_query(32'h7FFF_FFFF);

    // Full-range neighbors: distances need the extra bit
    set_count(COUNT_W'(2));
    put_store(0, 32'h8000_0000);
    put_store(1, 32'h7FFF_FFFF);
    put_query(32'h0000_0000);
    put_query(32'hFFFF_FFFF);

    // Ties go upward, exact hits stay, ends clamp
    set_count(COUNT_W'(3));
    put_store(0, 32'hFFFF_0000);
    put_store(1, 32'h0000_0000);
    put_store(2, 32'h0003_0000);
    put_store(TABLE_DEPTH - 1, 32'h7FFF_FFFF);
    put_query(32'hFFFE_0000);
    put_query(32'h0001_8000);
    put_query(32'h0001_7FFF);
    put_query(32'h0000_0000);
    put_query(32'hFFFF_8000);
    put_query(32'h7FFF_FFFF);

    // Descending table still gives a defined answer
    set_count(COUNT_W'(2));
    put_store(0, 32'h0005_0000);
    put_store(1, 32'hFFFB_0000);
    put_query(32'h0000_0000);

    // Full table, oversized count, then a sweep of small sizes
    random_phase(TABLE_DEPTH, 1'b1, 40);
    random_phase((1 << COUNT_W) - 1, 1'b0, 12);
    foreach (sizes[i]) random_phase(sizes[i], 1'b0, 4);
    drain();

    $display("Covered %0d stores and %0d queries over %0d count settings.",
             stores_taken, queries_taken, settings_used);
    $display("Checked %0d results, %0d errors.", results_seen, error_count);
    if (error_count == 0 && nearest_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a lost result
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/nsvl_pkg.sv
rtl/nsvl_ram.sv
rtl/nsvl_datapath.sv
rtl/nsvl_ctrl.sv
rtl/nearest_sorted_value_lookup.sv
verif/tb_nearest_sorted_value_lookup.sv
